@@ hw/rtl/mfq_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the scheduler.
package mfq_pkg;

  localparam int TASK_COUNT  = 64;
  localparam int LEVEL_COUNT = 4;
  localparam int RING_SLOTS  = 64;
  localparam int TID_W       = 6;
  localparam int LVL_W       = 2;
  localparam int IDX_W       = 6;
  localparam int TICK_W      = 4;
  localparam int RADDR_W     = LVL_W + IDX_W;
  localparam logic [TICK_W-1:0] TICK_MAX = 4'd15;

  typedef enum logic [2:0] {
    OP_CREATE, OP_MKRUN, OP_SLEEP, OP_PICK, OP_REQUEUE, OP_EXIT, OP_REAP, OP_BOOST
  } op_t;

  typedef enum logic [2:0] {
    ST_UNUSED, ST_EMBRYO, ST_SLEEPING, ST_RUNNABLE, ST_RUNNING, ST_ZOMBIE
  } status_t;

  typedef struct packed {
    status_t            st;
    logic [LVL_W-1:0]   lvl;
    logic [TICK_W-1:0]  ticks;
  } task_ent_t;

  typedef enum logic [1:0] {TA_TID, TA_CUR, TA_K, TA_RING} taddr_t;
  typedef enum logic [1:0] {TW_CREATE, TW_STATUS, TW_REQUEUE, TW_BOOST} twsel_t;
  typedef enum logic [1:0] {PL_TASK, PL_REQ, PL_ZERO} plvl_t;

  typedef enum logic [3:0] {
    R_NONE, R_LVL0, R_LVL_NEXT, R_PH_INIT, R_RD_IDX, R_RD_NEXT, R_RD_HEAD,
    R_IDX_INC, R_APPEND, R_MOVE, R_TRUNC, R_POP
  } ring_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TRD, S_DISP, S_FIN,
    S_PH_INIT, S_PH_CHK, S_PH_CMP, S_PH_ADD,
    S_RM_INIT, S_RM_CHK, S_RM_CMP, S_RM_SH, S_RM_MV,
    S_PK_CHK, S_PK_RD, S_PK_TK,
    S_BS_RD, S_BS_CHK, S_BS_NEXT
  } state_t;

  typedef struct packed {
    logic      capture;
    logic      task_rd;
    logic      task_wr;
    taddr_t    taddr;
    twsel_t    twsel;
    status_t   new_status;
    ring_op_t  ring_op;
    logic      load_cur;
    logic      cur_from_k;
    logic      load_plvl;
    plvl_t     plvl_sel;
    logic      set_pa;
    logic      pa_val;
    logic      k_clr;
    logic      k_inc;
    logic      res_set;
    logic      res_load;
  } cmd_t;

  typedef struct packed {
    op_t      op;
    status_t  st;
    logic     live;
    logic     demote;
    logic     ring_match;
    logic     idx_at_tail;
    logic     head_eq_tail;
    logic     ring_full;
    logic     next_at_tail;
    logic     lvl_last;
    logic     k_last;
    logic     pa;
    logic     out_free;
  } sts_t;

endpackage

@@ hw/rtl/multilevel_feedback_queue_scheduler.sv @@
// Top level of the multilevel feedback queue scheduler: controller plus datapath.
//
//   Channel  Ports                                            Direction
//   input    in_valid, in_ready, in_op, in_task_id            word in
//   result   out_valid, out_ready, out_found, out_chosen_task, out_chosen_level  word out
//
// Each word is handled alone: a duplicate check walks its ring entry by entry, removal
// scans the rings and then shifts the rest down, and boost visits each task slot in turn
// and does a duplicate-checked push for each runnable task.
// Reset is synchronous and leaves every ring empty and every task unused at once.
// A finished result waits in the output register; the next word is taken meanwhile.
module multilevel_feedback_queue_scheduler import mfq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_op,
  input  logic [TID_W-1:0]  in_task_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [TID_W-1:0]  out_chosen_task,
  output logic [LVL_W-1:0]  out_chosen_level
);

  cmd_t cmd;
  sts_t sts;

  mfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  mfq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_op            (in_op),
    .in_task_id       (in_task_id),
    .out_ready        (out_ready),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_chosen_task  (out_chosen_task),
    .out_chosen_level (out_chosen_level)
  );

endmodule

@@ hw/rtl/mfq_ctrl.sv @@
// Controller state machine that sequences each scheduling event over the datapath.
module mfq_ctrl import mfq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_t push_done, rm_done;
    push_done = (sts.op == OP_BOOST) ? S_BS_NEXT : S_FIN;
    rm_done   = sts.pa ? S_PH_INIT : S_FIN;
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_TRD;
        end
      end
      S_TRD: begin
        cmd.task_rd = 1'b1;
        cmd.taddr   = TA_TID;
        state_nxt   = S_DISP;
      end
      S_DISP: begin
        cmd.taddr = TA_TID;
        state_nxt = S_FIN;
        unique case (sts.op)
          OP_CREATE: begin
            if (sts.st == ST_UNUSED) begin
              cmd.task_wr = 1'b1;
              cmd.twsel   = TW_CREATE;
            end
          end
          OP_MKRUN: begin
            if (sts.live) begin
              cmd.task_wr    = 1'b1;
              cmd.twsel      = TW_STATUS;
              cmd.new_status = ST_RUNNABLE;
              cmd.load_cur   = 1'b1;
              cmd.load_plvl  = 1'b1;
              cmd.plvl_sel   = PL_TASK;
              state_nxt      = S_PH_INIT;
            end
          end
          OP_SLEEP, OP_EXIT: begin
            if (sts.live) begin
              cmd.task_wr    = 1'b1;
              cmd.twsel      = TW_STATUS;
              cmd.new_status = (sts.op == OP_SLEEP) ? ST_SLEEPING : ST_ZOMBIE;
              cmd.load_cur   = 1'b1;
              cmd.set_pa     = 1'b1;
              state_nxt      = S_RM_INIT;
            end
          end
          OP_REAP: begin
            if (sts.st == ST_ZOMBIE) begin
              cmd.task_wr    = 1'b1;
              cmd.twsel      = TW_STATUS;
              cmd.new_status = ST_UNUSED;
              cmd.load_cur   = 1'b1;
              cmd.set_pa     = 1'b1;
              state_nxt      = S_RM_INIT;
            end
          end
          OP_REQUEUE: begin
            if (sts.st == ST_RUNNING || sts.st == ST_RUNNABLE) begin
              cmd.task_wr   = 1'b1;
              cmd.twsel     = TW_REQUEUE;
              cmd.load_cur  = 1'b1;
              cmd.load_plvl = 1'b1;
              cmd.plvl_sel  = PL_REQ;
              cmd.set_pa    = 1'b1;
              cmd.pa_val    = 1'b1;
              state_nxt     = sts.demote ? S_RM_INIT : S_PH_INIT;
            end
          end
          OP_PICK: begin
            cmd.ring_op = R_LVL0;
            state_nxt   = S_PK_CHK;
          end
          default: begin
            cmd.k_clr = 1'b1;
            state_nxt = S_BS_RD;
          end
        endcase
      end
      S_PH_INIT: begin
        cmd.ring_op = R_PH_INIT;
        state_nxt   = S_PH_CHK;
      end
      S_PH_CHK: begin
        if (sts.idx_at_tail) begin
          state_nxt = S_PH_ADD;
        end else begin
          cmd.ring_op = R_RD_IDX;
          state_nxt   = S_PH_CMP;
        end
      end
      S_PH_CMP: begin
        if (sts.ring_match) begin
          state_nxt = push_done;
        end else begin
          cmd.ring_op = R_IDX_INC;
          state_nxt   = S_PH_CHK;
        end
      end
      S_PH_ADD: begin
        if (!sts.ring_full) cmd.ring_op = R_APPEND;
        state_nxt = push_done;
      end
      S_RM_INIT: begin
        cmd.ring_op = R_LVL0;
        state_nxt   = S_RM_CHK;
      end
      S_RM_CHK: begin
        if (sts.idx_at_tail) begin
          if (sts.lvl_last) begin
            state_nxt = rm_done;
          end else begin
            cmd.ring_op = R_LVL_NEXT;
          end
        end else begin
          cmd.ring_op = R_RD_IDX;
          state_nxt   = S_RM_CMP;
        end
      end
      S_RM_CMP: begin
        if (sts.ring_match) begin
          state_nxt = S_RM_SH;
        end else begin
          cmd.ring_op = R_IDX_INC;
          state_nxt   = S_RM_CHK;
        end
      end
      S_RM_SH: begin
        if (sts.next_at_tail) begin
          cmd.ring_op = R_TRUNC;
          state_nxt   = rm_done;
        end else begin
          cmd.ring_op = R_RD_NEXT;
          state_nxt   = S_RM_MV;
        end
      end
      S_RM_MV: begin
        cmd.ring_op = R_MOVE;
        state_nxt   = S_RM_SH;
      end
      S_PK_CHK: begin
        if (sts.head_eq_tail) begin
          if (sts.lvl_last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.ring_op = R_LVL_NEXT;
          end
        end else begin
          cmd.ring_op = R_RD_HEAD;
          state_nxt   = S_PK_RD;
        end
      end
      S_PK_RD: begin
        cmd.ring_op = R_POP;
        cmd.task_rd = 1'b1;
        cmd.taddr   = TA_RING;
        state_nxt   = S_PK_TK;
      end
      S_PK_TK: begin
        if (sts.st == ST_RUNNABLE) begin
          cmd.ring_op    = R_APPEND;
          cmd.task_wr    = 1'b1;
          cmd.taddr      = TA_CUR;
          cmd.twsel      = TW_STATUS;
          cmd.new_status = ST_RUNNING;
          cmd.res_set    = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_PK_CHK;
        end
      end
      S_BS_RD: begin
        cmd.task_rd = 1'b1;
        cmd.taddr   = TA_K;
        state_nxt   = S_BS_CHK;
      end
      S_BS_CHK: begin
        cmd.taddr = TA_K;
        state_nxt = S_BS_NEXT;
        if (sts.live) begin
          cmd.task_wr = 1'b1;
          cmd.twsel   = TW_BOOST;
          if (sts.st == ST_RUNNABLE) begin
            cmd.load_cur   = 1'b1;
            cmd.cur_from_k = 1'b1;
            cmd.load_plvl  = 1'b1;
            cmd.plvl_sel   = PL_ZERO;
            state_nxt      = S_PH_INIT;
          end
        end
      end
      S_BS_NEXT: begin
        if (sts.k_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_BS_RD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/mfq_dp.sv @@
// Datapath with the ring memory, task table, ring pointers and the result register.
module mfq_dp import mfq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [2:0]        in_op,
  input  logic [TID_W-1:0]  in_task_id,
  input  logic              out_ready,
  output sts_t              sts,
  output logic              out_valid,
  output logic              out_found,
  output logic [TID_W-1:0]  out_chosen_task,
  output logic [LVL_W-1:0]  out_chosen_level
);

  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] i);
    step_idx = (i == IDX_W'(RING_SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [TID_W-1:0]  ring_mem [LEVEL_COUNT*RING_SLOTS];
  task_ent_t         task_mem [TASK_COUNT];
  logic [TASK_COUNT-1:0] tvalid_r;

  op_t               op_r;
  logic [TID_W-1:0]  tid_r, cur_r, k_r, ring_q_r;
  logic [LVL_W-1:0]  lvl_r, plvl_r;
  logic [IDX_W-1:0]  idx_r;
  logic              pa_r;
  logic [IDX_W-1:0]  head_r [LEVEL_COUNT];
  logic [IDX_W-1:0]  tail_r [LEVEL_COUNT];
  task_ent_t         task_rd_r;
  logic              tv_rd_r;
  logic              res_found_r, out_valid_r, out_found_r;
  logic [TID_W-1:0]  res_task_r, out_task_r;
  logic [LVL_W-1:0]  res_lvl_r, out_lvl_r;

  task_ent_t         task_q, task_wdata;
  logic [TID_W-1:0]  taddr;
  logic [IDX_W-1:0]  hd, tl;
  logic [LVL_W-1:0]  lvl_nx, req_lvl, new_plvl;
  logic [TICK_W-1:0] tk_inc;
  logic [8:0]        thr;
  logic              demote;
  logic              ring_re, ring_we;
  logic [RADDR_W-1:0] ring_raddr, ring_waddr;
  logic [TID_W-1:0]  ring_wdata;

  assign task_q = tv_rd_r ? task_rd_r : '0;
  assign hd     = head_r[lvl_r];
  assign tl     = tail_r[lvl_r];
  assign lvl_nx = lvl_r + 1'b1;
  assign tk_inc = (task_q.ticks == TICK_MAX) ? TICK_MAX : task_q.ticks + 1'b1;
  assign thr    = 9'd1 << task_q.lvl;
  assign demote = (task_q.lvl != LVL_W'(LEVEL_COUNT - 1)) &&
                  ({{(9-TICK_W){1'b0}}, tk_inc} >= thr);
  assign req_lvl = demote ? task_q.lvl + 1'b1 : task_q.lvl;

  always_comb begin
    unique case (cmd.taddr)
      TA_TID:  taddr = tid_r;
      TA_CUR:  taddr = cur_r;
      TA_K:    taddr = k_r;
      default: taddr = ring_q_r;
    endcase
    unique case (cmd.twsel)
      TW_CREATE:  task_wdata = '{st: ST_EMBRYO, lvl: '0, ticks: '0};
      TW_STATUS:  task_wdata = '{st: cmd.new_status, lvl: task_q.lvl, ticks: task_q.ticks};
      TW_REQUEUE: task_wdata = '{st: ST_RUNNABLE, lvl: req_lvl,
                                 ticks: (demote ? '0 : tk_inc)};
      default:    task_wdata = '{st: task_q.st, lvl: '0, ticks: '0};
    endcase
    unique case (cmd.plvl_sel)
      PL_TASK: new_plvl = task_q.lvl;
      PL_REQ:  new_plvl = req_lvl;
      default: new_plvl = '0;
    endcase
  end

  always_comb begin
    ring_re    = 1'b0;
    ring_we    = 1'b0;
    ring_raddr = {lvl_r, idx_r};
    ring_waddr = {lvl_r, tl};
    ring_wdata = cur_r;
    unique case (cmd.ring_op)
      R_RD_IDX:  ring_re = 1'b1;
      R_RD_NEXT: begin
        ring_re    = 1'b1;
        ring_raddr = {lvl_r, step_idx(idx_r)};
      end
      R_RD_HEAD: begin
        ring_re    = 1'b1;
        ring_raddr = {lvl_r, hd};
      end
      R_APPEND:  ring_we = 1'b1;
      R_MOVE: begin
        ring_we    = 1'b1;
        ring_waddr = {lvl_r, idx_r};
        ring_wdata = ring_q_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    if (ring_re) ring_q_r <= ring_mem[ring_raddr];
    if (cmd.task_wr) task_mem[taddr] <= task_wdata;
    if (cmd.task_rd) begin
      task_rd_r <= task_mem[taddr];
      tv_rd_r   <= tvalid_r[taddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r    <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
      end
    end else begin
      if (cmd.task_wr) tvalid_r[taddr] <= 1'b1;
      if (cmd.res_load)  out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (cmd.ring_op)
        R_APPEND: tail_r[lvl_r] <= step_idx(tl);
        R_TRUNC:  tail_r[lvl_r] <= idx_r;
        R_POP:    head_r[lvl_r] <= step_idx(hd);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= op_t'(in_op);
      tid_r       <= in_task_id;
      res_found_r <= 1'b0;
      res_task_r  <= '0;
      res_lvl_r   <= '0;
    end
    if (cmd.res_set) begin
      res_found_r <= 1'b1;
      res_task_r  <= cur_r;
      res_lvl_r   <= lvl_r;
    end
    if (cmd.res_load) begin
      out_found_r <= res_found_r;
      out_task_r  <= res_task_r;
      out_lvl_r   <= res_lvl_r;
    end
    if (cmd.load_cur)  cur_r  <= cmd.cur_from_k ? k_r : tid_r;
    if (cmd.load_plvl) plvl_r <= new_plvl;
    if (cmd.set_pa)    pa_r   <= cmd.pa_val;
    if (cmd.k_clr)      k_r <= '0;
    else if (cmd.k_inc) k_r <= k_r + 1'b1;
    unique case (cmd.ring_op)
      R_LVL0: begin
        lvl_r <= '0;
        idx_r <= head_r[0];
      end
      R_LVL_NEXT: begin
        lvl_r <= lvl_nx;
        idx_r <= head_r[lvl_nx];
      end
      R_PH_INIT: begin
        lvl_r <= plvl_r;
        idx_r <= head_r[plvl_r];
      end
      R_IDX_INC, R_MOVE: idx_r <= step_idx(idx_r);
      R_POP:             cur_r <= ring_q_r;
      default: ;
    endcase
  end

  always_comb begin
    sts.op           = op_r;
    sts.st           = task_q.st;
    sts.live         = (task_q.st != ST_UNUSED) && (task_q.st != ST_ZOMBIE);
    sts.demote       = demote;
    sts.ring_match   = (ring_q_r == cur_r);
    sts.idx_at_tail  = (idx_r == tl);
    sts.head_eq_tail = (hd == tl);
    sts.ring_full    = (step_idx(tl) == hd);
    sts.next_at_tail = (step_idx(idx_r) == tl);
    sts.lvl_last     = (lvl_r == LVL_W'(LEVEL_COUNT - 1));
    sts.k_last       = (k_r == TID_W'(TASK_COUNT - 1));
    sts.pa           = pa_r;
    sts.out_free     = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_chosen_task  = out_task_r;
  assign out_chosen_level = out_lvl_r;

endmodule

@@ dv/mfq_checker.sv @@
// Scheduler checker: predicts the result of every input word and compares result words.
module mfq_checker import mfq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        in_op,
  input  logic [TID_W-1:0]  in_task_id,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_found,
  input  logic [TID_W-1:0]  out_chosen_task,
  input  logic [LVL_W-1:0]  out_chosen_level,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic              found;
    logic [TID_W-1:0]  tid;
    logic [LVL_W-1:0]  lvl;
  } pick_res_t;

  logic              slot_ok [LEVEL_COUNT][RING_SLOTS];
  logic [TID_W-1:0]  slot_tid[LEVEL_COUNT][RING_SLOTS];
  logic [IDX_W-1:0]  rhead[LEVEL_COUNT];
  logic [IDX_W-1:0]  rtail[LEVEL_COUNT];
  status_t           tstat[TASK_COUNT];
  logic [LVL_W-1:0]  tlvl[TASK_COUNT];
  logic [TICK_W-1:0] tticks[TASK_COUNT];
  pick_res_t         expected_q[$];

  function automatic bit ring_holds(int l, int t);
    logic [IDX_W-1:0] i;
    i = rhead[l];
    while (i != rtail[l]) begin
      if (slot_ok[l][i] && slot_tid[l][i] == t) return 1;
      i = i + 1'b1;
    end
    return 0;
  endfunction

  function automatic void ring_append(int l, int t);
    logic [IDX_W-1:0] nt;
    if (ring_holds(l, t)) return;
    nt = rtail[l] + 1'b1;
    if (nt == rhead[l]) return;
    slot_ok[l][rtail[l]] = 1'b1;
    slot_tid[l][rtail[l]] = TID_W'(t);
    rtail[l] = nt;
  endfunction

  function automatic void ring_drop(int t);
    logic [TID_W-1:0] keep[$];
    logic [IDX_W-1:0] i;
    bit hit;
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      hit = 0;
      keep.delete();
      i = rhead[l];
      while (i != rtail[l]) begin
        if (slot_ok[l][i]) begin
          if (slot_tid[l][i] == t) hit = 1;
          else keep.push_back(slot_tid[l][i]);
        end
        i = i + 1'b1;
      end
      if (hit) begin
        rhead[l] = '0;
        rtail[l] = '0;
        for (int s = 0; s < RING_SLOTS; s++) begin
          slot_ok[l][s] = 1'b0;
          slot_tid[l][s] = '0;
        end
        foreach (keep[k]) ring_append(l, keep[k]);
        return;
      end
    end
  endfunction

  function automatic bit is_live(int t);
    return tstat[t] != ST_UNUSED && tstat[t] != ST_ZOMBIE;
  endfunction

  function automatic pick_res_t schedule_event(op_t op, int t);
    pick_res_t r;
    int lv;
    r = '0;
    case (op)
      OP_CREATE: if (tstat[t] == ST_UNUSED) begin
        tstat[t] = ST_EMBRYO;
        tlvl[t] = '0;
        tticks[t] = '0;
      end
      OP_MKRUN: if (is_live(t)) begin
        tstat[t] = ST_RUNNABLE;
        ring_append(int'(tlvl[t]), t);
      end
      OP_SLEEP, OP_EXIT: if (is_live(t)) begin
        ring_drop(t);
        tstat[t] = (op == OP_SLEEP) ? ST_SLEEPING : ST_ZOMBIE;
      end
      OP_PICK: begin
        for (int l = 0; l < LEVEL_COUNT; l++) begin
          while (rhead[l] != rtail[l]) begin
            logic ok;
            logic [TID_W-1:0] id;
            ok = slot_ok[l][rhead[l]];
            id = slot_tid[l][rhead[l]];
            slot_ok[l][rhead[l]] = 1'b0;
            slot_tid[l][rhead[l]] = '0;
            rhead[l] = rhead[l] + 1'b1;
            if (ok && tstat[id] == ST_RUNNABLE) begin
              ring_append(l, int'(id));
              tstat[id] = ST_RUNNING;
              r.found = 1'b1;
              r.tid = id;
              r.lvl = LVL_W'(l);
              return r;
            end
          end
        end
      end
      OP_REQUEUE: if (tstat[t] == ST_RUNNING || tstat[t] == ST_RUNNABLE) begin
        lv = int'(tlvl[t]);
        tstat[t] = ST_RUNNABLE;
        if (tticks[t] < TICK_MAX) tticks[t] = tticks[t] + 1'b1;
        if (lv + 1 < LEVEL_COUNT && tticks[t] >= (1 << lv)) begin
          tticks[t] = '0;
          ring_drop(t);
          tlvl[t] = LVL_W'(lv + 1);
        end
        ring_append(int'(tlvl[t]), t);
      end
      OP_REAP: if (tstat[t] == ST_ZOMBIE) begin
        ring_drop(t);
        tstat[t] = ST_UNUSED;
      end
      default: for (int k = 0; k < TASK_COUNT; k++) begin
        if (is_live(k)) begin
          tlvl[k] = '0;
          tticks[k] = '0;
          if (tstat[k] == ST_RUNNABLE) ring_append(0, k);
        end
      end
    endcase
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    pick_res_t e;
    int bad;
    bad = 0;
    if (!rst_n) begin
      errors <= 0;
      expected_q.delete();
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        rhead[l] = '0;
        rtail[l] = '0;
        for (int s = 0; s < RING_SLOTS; s++) begin
          slot_ok[l][s] = 1'b0;
          slot_tid[l][s] = '0;
        end
      end
      for (int t = 0; t < TASK_COUNT; t++) begin
        tstat[t] = ST_UNUSED;
        tlvl[t] = '0;
        tticks[t] = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no expectation waiting");
          bad++;
        end else begin
          e = expected_q.pop_front();
          if (out_found !== e.found) begin
            $error("found: expected %0d, actual %0d", e.found, out_found);
            bad++;
          end
          if (out_chosen_task !== e.tid) begin
            $error("chosen_task: expected %0d, actual %0d", e.tid, out_chosen_task);
            bad++;
          end
          if (out_chosen_level !== e.lvl) begin
            $error("chosen_level: expected %0d, actual %0d", e.lvl, out_chosen_level);
            bad++;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
      if (in_valid && in_ready)
        expected_q.push_back(schedule_event(op_t'(in_op), int'(in_task_id)));
    end
  end

endmodule

@@ dv/tb.sv @@
// Testbench top of the scheduler: clock, reset, word stimulus, receiver stalls and verdict.
module tb import mfq_pkg::*;;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_op = '0;
  logic [TID_W-1:0]  in_task_id = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_found;
  logic [TID_W-1:0]  out_chosen_task;
  logic [LVL_W-1:0]  out_chosen_level;
  int                errors;
  int                pending;
  bit                hold_rx = 0;
  int                burst_left = 0;

  always #2 clk = ~clk;

  multilevel_feedback_queue_scheduler i_dut (.*);

  mfq_checker i_checker (.*);

  task automatic send_word(op_t op, int tid);
    in_valid <= 1'b1;
    in_op <= op;
    in_task_id <= TID_W'(tid);
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  endtask

  function automatic int pick_tid();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, TASK_COUNT - 1);
    return $urandom_range(0, 9);
  endfunction

  function automatic op_t pick_op();
    int w;
    w = $urandom_range(0, 99);
    if (w < 10) return OP_CREATE;
    if (w < 28) return OP_MKRUN;
    if (w < 36) return OP_SLEEP;
    if (w < 60) return OP_PICK;
    if (w < 80) return OP_REQUEUE;
    if (w < 88) return OP_EXIT;
    if (w < 96) return OP_REAP;
    return OP_BOOST;
  endfunction

  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_rx = 0;
      end else begin
        if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  initial begin
    #200_000_000;
    $display("** multilevel_feedback_queue_scheduler: FAILED **");
    $finish;
  end

  initial begin
    int t;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_CREATE, 0);
    send_word(OP_CREATE, 63);
    send_word(OP_CREATE, 0);
    send_word(OP_MKRUN, 0);
    send_word(OP_MKRUN, 63);
    send_word(OP_MKRUN, 0);
    send_word(OP_MKRUN, 5);
    send_word(OP_PICK, 42);
    send_word(OP_REQUEUE, 0);
    send_word(OP_REQUEUE, 0);
    send_word(OP_REQUEUE, 0);
    send_word(OP_REQUEUE, 0);
    send_word(OP_PICK, 0);
    send_word(OP_SLEEP, 63);
    send_word(OP_PICK, 0);
    send_word(OP_REAP, 0);
    send_word(OP_EXIT, 0);
    send_word(OP_MKRUN, 0);
    send_word(OP_REAP, 0);
    send_word(OP_REQUEUE, 7);
    send_word(OP_MKRUN, 63);
    send_word(OP_BOOST, 21);
    send_word(OP_PICK, 0);
    send_word(OP_PICK, 0);
    send_word(OP_BOOST, 0);

    for (int n = 0; n < 1000; n++) begin
      if (n == 300) begin
        for (int k = 0; k < TASK_COUNT; k++) send_word(OP_CREATE, k);
        for (int k = 0; k < TASK_COUNT; k++) send_word(OP_MKRUN, k);
        send_word(OP_PICK, 0);
      end
      if (n == 600) hold_rx = 1;
      if (n == 900) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        t = pick_tid();
        send_word(OP_CREATE, t);
        send_word(OP_MKRUN, t);
        repeat ($urandom_range(1, 4)) begin
          send_word(OP_PICK, 0);
          send_word(OP_REQUEUE, t);
        end
        if ($urandom_range(0, 1)) begin
          send_word(OP_EXIT, t);
          send_word(OP_REAP, t);
        end
      end else begin
        send_word(pick_op(), pick_tid());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0)
      $display("** multilevel_feedback_queue_scheduler: PASSED **");
    else
      $display("** multilevel_feedback_queue_scheduler: FAILED **");
    $finish;
  end

endmodule
